@@ src/assert_macros.svh @@
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// next-cycle implication checked while out of reset
`define ASSERT_NEXT(label, cond, res, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (res)) else $error(msg);

`endif

@@ src/amss_pkg.sv @@
package amss_pkg;

    // sample range and speed limits
    localparam logic signed [15:0] SampleMax = 16'sh7fff;
    localparam logic signed [15:0] SampleMin = 16'sh8000;
    localparam int SpeedMin  = 50;
    localparam int SpeedMax  = 1000;
    localparam int SpeedUnit = 100;
    localparam int ScaleMax  = SpeedMax / SpeedUnit;

    // configuration register indexes
    localparam logic CFG_SPEED   = 1'b0;
    localparam logic CFG_SID_MIX = 1'b1;

    // rate class of the current speed
    typedef enum logic [1:0] {
        MODE_SLOW,
        MODE_NORMAL,
        MODE_FAST
    } t_mode;

    // one queued result: a stereo pair, emitted once or twice
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               dbl;
    } t_entry;

    // queue fill flags seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // signed 16-bit add clipped to the sample range
    function automatic logic signed [15:0] sat_add(
        input logic signed [15:0] a,
        input logic signed [15:0] b
    );
        logic signed [16:0] s;
        logic signed [15:0] r;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            r = s[16] ? SampleMin : SampleMax;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

    // rate class after clamping to the speed limits
    function automatic t_mode mode_of(input logic [9:0] speed);
        t_mode m;
        if (int'(speed) < SpeedUnit) begin
            m = MODE_SLOW;
        end else if (int'(speed) == SpeedUnit) begin
            m = MODE_NORMAL;
        end else begin
            m = MODE_FAST;
        end
        return m;
    endfunction

    // group length in fast mode: clamped speed over one hundred
    function automatic logic [3:0] scale_of(input logic [9:0] speed);
        logic [3:0] s;
        s = 4'd1;
        for (int k = 2; k <= ScaleMax; k++) begin
            if (int'(speed) >= k * SpeedUnit) begin
                s = s + 4'd1;
            end
        end
        return s;
    endfunction

endpackage

@@ src/audio_mix_and_speed_scale.sv @@
// channel  | valid   | stall   | payload
// input    | i_valid | o_stall | dac, chip and sid per side, frame_last
// output   | o_valid | i_stall | out_left, out_right, run_last
// config   | i_cfg_we (no stall) | i_cfg_index, i_cfg_data
//
// an input beat is mixed and classified in the cycle it is accepted, and any result it
// completes is queued in that cycle; it then passes from the queue to the output register
// one input beat a cycle at normal and fast speed while the queue has room; at slow speed
// the single output register sends each slow result twice, so o_stall holds input back
// two-entry queue between front and back; o_stall is high only while it is full
// synchronous active-low reset; speed resets to normal, sid mix off
`include "assert_macros.svh"

module audio_mix_and_speed_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_dac_left,
    input  logic signed [15:0] i_dac_right,
    input  logic signed [15:0] i_chip_left,
    input  logic signed [15:0] i_chip_right,
    input  logic signed [15:0] i_sid_left,
    input  logic signed [15:0] i_sid_right,
    input  logic               i_frame_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_right,
    output logic               o_run_last
);

    logic                 w_accept;
    logic                 w_push;
    logic                 w_pop;
    amss_pkg::t_entry     w_push_entry;
    amss_pkg::t_entry     w_head_entry;
    amss_pkg::t_fifo_stat w_stat;

    // input beat taken while the queue has room
    assign o_stall  = w_stat.full;
    assign w_accept = i_valid && !w_stat.full;

    // mix and classify
    amss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_dac_left   (i_dac_left),
        .i_dac_right  (i_dac_right),
        .i_chip_left  (i_chip_left),
        .i_chip_right (i_chip_right),
        .i_sid_left   (i_sid_left),
        .i_sid_right  (i_sid_right),
        .i_frame_last (i_frame_last),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // queue between the two sides
    amss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_stat)
    );

    // result emission
    amss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_head_entry),
        .i_stat      (w_stat),
        .o_pop       (w_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_left  (o_out_left),
        .o_out_right (o_out_right),
        .o_run_last  (o_run_last)
    );

    // checks
    `ASSERT_CLK(a_no_overflow, w_push |-> !w_stat.full, "push into a full queue")
    `ASSERT_CLK(a_no_underflow, w_pop |-> !w_stat.empty, "pop from an empty queue")
    `ASSERT_NEXT(a_repeat_follows, o_valid && !o_run_last && !i_stall, o_valid && o_run_last, "second beat of a slow result missing")

endmodule

@@ src/amss_front.sv @@
module amss_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [9:0]            i_cfg_data,
    input  logic                  i_accept,
    input  logic signed [15:0]    i_dac_left,
    input  logic signed [15:0]    i_dac_right,
    input  logic signed [15:0]    i_chip_left,
    input  logic signed [15:0]    i_chip_right,
    input  logic signed [15:0]    i_sid_left,
    input  logic signed [15:0]    i_sid_right,
    input  logic                  i_frame_last,
    output logic                  o_push,
    output amss_pkg::t_entry      o_entry
);

    amss_pkg::t_mode    r_mode, n_mode;
    logic [3:0]         r_scale, n_scale;
    logic               r_sid_en, n_sid_en;
    logic [3:0]         r_group, n_group;
    logic signed [15:0] r_held_left, n_held_left;
    logic signed [15:0] r_held_right, n_held_right;
    logic signed [15:0] w_mix_left, w_mix_right;
    logic [4:0]         w_group_inc;

    // per-channel mix, sid added with a second clip when enabled
    always_comb begin
        w_mix_left  = amss_pkg::sat_add(i_dac_left, i_chip_left);
        w_mix_right = amss_pkg::sat_add(i_dac_right, i_chip_right);
        if (r_sid_en) begin
            w_mix_left  = amss_pkg::sat_add(w_mix_left, i_sid_left);
            w_mix_right = amss_pkg::sat_add(w_mix_right, i_sid_right);
        end
    end

    assign w_group_inc = {1'b0, r_group} + 5'd1;

    // configuration decode, rate class worked out at write time
    always_comb begin
        n_mode   = r_mode;
        n_scale  = r_scale;
        n_sid_en = r_sid_en;
        if (i_cfg_we) begin
            case (i_cfg_index)
                amss_pkg::CFG_SPEED: begin
                    n_mode  = amss_pkg::mode_of(i_cfg_data);
                    n_scale = amss_pkg::scale_of(i_cfg_data);
                end
                amss_pkg::CFG_SID_MIX: begin
                    n_sid_en = i_cfg_data[0];
                end
                default: begin
                    n_sid_en = r_sid_en;
                end
            endcase
        end
    end

    // classify the beat and keep group state
    always_comb begin
        n_group      = r_group;
        n_held_left  = r_held_left;
        n_held_right = r_held_right;
        o_push       = 1'b0;
        o_entry      = '{left: w_mix_left, right: w_mix_right, dbl: 1'b0};
        if (i_accept) begin
            case (r_mode)
                amss_pkg::MODE_SLOW: begin
                    o_push      = 1'b1;
                    o_entry.dbl = 1'b1;
                    n_group     = 4'd0;
                end
                amss_pkg::MODE_NORMAL: begin
                    o_push  = 1'b1;
                    n_group = 4'd0;
                end
                amss_pkg::MODE_FAST: begin
                    if (r_group == 4'd0) begin
                        n_held_left  = w_mix_left;
                        n_held_right = w_mix_right;
                    end else begin
                        o_entry.left  = r_held_left;
                        o_entry.right = r_held_right;
                    end
                    if (w_group_inc >= {1'b0, r_scale}) begin
                        o_push  = 1'b1;
                        n_group = 4'd0;
                    end else begin
                        n_group = w_group_inc[3:0];
                    end
                end
                default: begin
                    n_group = 4'd0;
                end
            endcase
            if (i_frame_last) begin
                n_group = 4'd0;
            end
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= amss_pkg::MODE_NORMAL;
            r_scale      <= 4'd1;
            r_sid_en     <= 1'b0;
            r_group      <= 4'd0;
            r_held_left  <= '0;
            r_held_right <= '0;
        end else begin
            r_mode       <= n_mode;
            r_scale      <= n_scale;
            r_sid_en     <= n_sid_en;
            r_group      <= n_group;
            r_held_left  <= n_held_left;
            r_held_right <= n_held_right;
        end
    end

endmodule

@@ src/amss_fifo.sv @@
module amss_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  amss_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output amss_pkg::t_entry      o_entry,
    output amss_pkg::t_fifo_stat  o_stat
);

    amss_pkg::t_entry r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ src/amss_back.sv @@
module amss_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  amss_pkg::t_entry      i_entry,
    input  amss_pkg::t_fifo_stat  i_stat,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic signed [15:0]    o_out_left,
    output logic signed [15:0]    o_out_right,
    output logic                  o_run_last
);

    logic               r_valid, n_valid;
    logic               r_rep, n_rep;
    logic               r_last, n_last;
    logic signed [15:0] r_left, n_left;
    logic signed [15:0] r_right, n_right;
    logic               w_load;

    // output slot is free when empty or being taken
    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && !r_rep && !i_stat.empty;

    // repeat a slow beat, else take the queue head
    always_comb begin
        n_valid = r_valid;
        n_rep   = r_rep;
        n_last  = r_last;
        n_left  = r_left;
        n_right = r_right;
        if (w_load) begin
            if (r_rep) begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_rep   = 1'b0;
            end else if (!i_stat.empty) begin
                n_valid = 1'b1;
                n_left  = i_entry.left;
                n_right = i_entry.right;
                n_last  = !i_entry.dbl;
                n_rep   = i_entry.dbl;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rep   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_rep   <= n_rep;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_valid     = r_valid;
    assign o_out_left  = r_left;
    assign o_out_right = r_right;
    assign o_run_last  = r_last;

endmodule

@@ tb/audio_mix_and_speed_scale_tb.sv @@
module audio_mix_and_speed_scale_tb;

    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 80;
    localparam int PhaseBeats   = 50;
    localparam int PhaseCount   = 17;

    // one input beat: three stereo sources and the frame marker
    typedef struct {
        logic signed [15:0] dac_l;
        logic signed [15:0] dac_r;
        logic signed [15:0] chip_l;
        logic signed [15:0] chip_r;
        logic signed [15:0] sid_l;
        logic signed [15:0] sid_r;
        logic               last;
    } t_mix_frame;

    // one output beat
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } t_pcm_pair;

    // mixes each accepted frame, applies the rate scaling and checks the output beats
    class t_pcm_mix_tracker;
        logic [9:0]         speed;
        logic               sid_en;
        logic [3:0]         group_cnt;
        logic signed [15:0] held_l;
        logic signed [15:0] held_r;
        t_pcm_pair          due_pairs[$];
        int                 frames;
        int                 pairs;
        int                 errors;

        function new();
            speed     = 10'd100;
            sid_en    = 1'b0;
            group_cnt = '0;
            held_l    = '0;
            held_r    = '0;
            frames    = 0;
            pairs     = 0;
            errors    = 0;
        endfunction

        function void write_reg(input logic index, input logic [9:0] data);
            if (index == amss_pkg::CFG_SPEED) begin
                speed = data;
            end else begin
                sid_en = data[0];
            end
        endfunction

        // widen, add and clip to the sample range
        function logic signed [15:0] clip_add(input logic signed [15:0] a, b);
            int s;
            s = int'(a) + int'(b);
            if (s > int'(amss_pkg::SampleMax)) s = int'(amss_pkg::SampleMax);
            if (s < int'(amss_pkg::SampleMin)) s = int'(amss_pkg::SampleMin);
            return 16'(s);
        endfunction

        function logic signed [15:0] mix_side(input logic signed [15:0] dac, chip, sid);
            logic signed [15:0] s;
            s = clip_add(dac, chip);
            if (sid_en) s = clip_add(s, sid);
            return s;
        endfunction

        function void note_frame(input t_mix_frame f);
            logic signed [15:0] l;
            logic signed [15:0] r;
            int                 eff;
            int                 scale;
            amss_pkg::t_mode    mode;
            l   = mix_side(f.dac_l, f.chip_l, f.sid_l);
            r   = mix_side(f.dac_r, f.chip_r, f.sid_r);
            eff = int'(speed);
            if (eff < amss_pkg::SpeedMin) eff = amss_pkg::SpeedMin;
            if (eff > amss_pkg::SpeedMax) eff = amss_pkg::SpeedMax;
            if (eff < amss_pkg::SpeedUnit) mode = amss_pkg::MODE_SLOW;
            else if (eff == amss_pkg::SpeedUnit) mode = amss_pkg::MODE_NORMAL;
            else mode = amss_pkg::MODE_FAST;
            case (mode)
                amss_pkg::MODE_SLOW: begin
                    due_pairs.push_back(t_pcm_pair'{l, r, 1'b0});
                    due_pairs.push_back(t_pcm_pair'{l, r, 1'b1});
                    group_cnt = '0;
                end
                amss_pkg::MODE_NORMAL: begin
                    due_pairs.push_back(t_pcm_pair'{l, r, 1'b1});
                    group_cnt = '0;
                end
                default: begin
                    // first frame of a group is held, sent once the group is complete
                    scale = eff / amss_pkg::SpeedUnit;
                    if (group_cnt == 4'd0) begin
                        held_l = l;
                        held_r = r;
                    end
                    if (int'(group_cnt) + 1 >= scale) begin
                        due_pairs.push_back(t_pcm_pair'{held_l, held_r, 1'b1});
                        group_cnt = '0;
                    end else begin
                        group_cnt = group_cnt + 4'd1;
                    end
                end
            endcase
            // frame end drops a partial group
            if (f.last) group_cnt = '0;
            frames++;
        endfunction

        function void check_pair(input logic signed [15:0] l, r, input logic last);
            t_pcm_pair e;
            if (due_pairs.size() == 0) begin
                $error("output beat with nothing pending: left %0d right %0d", l, r);
                errors++;
                return;
            end
            e = due_pairs.pop_front();
            pairs++;
            if (l !== e.left) begin
                $error("out_left: expected %0d, got %0d", e.left, l);
                errors++;
            end
            if (r !== e.right) begin
                $error("out_right: expected %0d, got %0d", e.right, r);
                errors++;
            end
            if (last !== e.last) begin
                $error("run_last: expected %0b, got %0b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_pairs.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [9:0]         i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_dac_left;
    logic signed [15:0] i_dac_right;
    logic signed [15:0] i_chip_left;
    logic signed [15:0] i_chip_right;
    logic signed [15:0] i_sid_left;
    logic signed [15:0] i_sid_right;
    logic               i_frame_last;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_out_left;
    logic signed [15:0] o_out_right;
    logic               o_run_last;

    t_pcm_mix_tracker tracker;
    int               cycle_cnt;
    int               setting_cnt;
    bit               hold_req;
    bit               tx_calm;
    bit               rx_calm;

    audio_mix_and_speed_scale u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_dac_left   (i_dac_left),
        .i_dac_right  (i_dac_right),
        .i_chip_left  (i_chip_left),
        .i_chip_right (i_chip_right),
        .i_sid_left   (i_sid_left),
        .i_sid_right  (i_sid_right),
        .i_frame_last (i_frame_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_left   (o_out_left),
        .o_out_right  (o_out_right),
        .o_run_last   (o_run_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CycleLimit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // output beats are checked before the input beat of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                tracker.check_pair(o_out_left, o_out_right, o_run_last);
            end
            if (i_valid && !o_stall) begin
                tracker.note_frame(t_mix_frame'{i_dac_left, i_dac_right, i_chip_left,
                    i_chip_right, i_sid_left, i_sid_right, i_frame_last});
            end
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int pick_stretch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int pick_gap();
        if (tx_calm || $urandom_range(0, 1) == 0) return 0;
        return pick_stretch();
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_run;
        stall_run = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (int c = 0; c < HoldCycles; c++) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_calm) begin
                i_stall <= 1'b0;
            end else if (stall_run > 0) begin
                i_stall <= 1'b1;
                stall_run--;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) stall_run = pick_stretch();
            end
        end
    end

    // sample values biased towards the clipping edges
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return amss_pkg::SampleMax;
            1: return amss_pkg::SampleMin;
            2: return 16'($urandom_range(0, 511)) - 16'sd256;
            3: return 16'sh7000 | 16'($urandom_range(0, 16'h0fff));
            4: return 16'sh8000 | 16'($urandom_range(0, 16'h0fff));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_mix_frame make_frame(
        input logic signed [15:0] dac_l, dac_r, chip_l, chip_r, sid_l, sid_r,
        input logic last
    );
        return t_mix_frame'{dac_l, dac_r, chip_l, chip_r, sid_l, sid_r, last};
    endfunction

    function automatic t_mix_frame pick_frame(input int last_odds);
        return make_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
            pick_sample(), pick_sample(), $urandom_range(0, last_odds - 1) == 0);
    endfunction

    // offer one beat after an idle gap and wait for it to be taken
    task automatic drive_frame(input t_mix_frame f, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_dac_left   <= f.dac_l;
        i_dac_right  <= f.dac_r;
        i_chip_left  <= f.chip_l;
        i_chip_right <= f.chip_r;
        i_sid_left   <= f.sid_l;
        i_sid_right  <= f.sid_r;
        i_frame_last <= f.last;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid, wait for every pending output beat, then let the block settle
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [9:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.write_reg(index, data);
        setting_cnt++;
    endtask

    task automatic run_random(input int beats, input int last_odds);
        for (int k = 0; k < beats; k++) drive_frame(pick_frame(last_odds), pick_gap());
    endtask

    // stimulus
    initial begin
        int speeds[16];
        int spd;
        speeds = '{0, 49, 50, 99, 100, 101, 199, 200, 250, 300, 499, 700, 999, 1000,
            1001, 1023};
        tracker      = new();
        setting_cnt  = 0;
        hold_req     = 1'b0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = amss_pkg::CFG_SPEED;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_dac_left   = '0;
        i_dac_right  = '0;
        i_chip_left  = '0;
        i_chip_right = '0;
        i_sid_left   = '0;
        i_sid_right  = '0;
        i_frame_last = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // normal speed, sid off: clipping both ways, sid ignored
        write_reg(amss_pkg::CFG_SPEED, 10'd100);
        write_reg(amss_pkg::CFG_SID_MIX, 10'd0);
        drive_frame(make_frame(amss_pkg::SampleMax, amss_pkg::SampleMin,
            amss_pkg::SampleMax, amss_pkg::SampleMin, 16'sd0, 16'sd0, 1'b0), 0);
        drive_frame(make_frame(amss_pkg::SampleMin, amss_pkg::SampleMax,
            -16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0), 0);
        drive_frame(make_frame(amss_pkg::SampleMax, amss_pkg::SampleMin,
            amss_pkg::SampleMin, amss_pkg::SampleMax,
            amss_pkg::SampleMax, amss_pkg::SampleMin, 1'b1), 1);
        drive_frame(make_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, -16'sd1, 1'b0), 0);
        settle();

        // sid on: first clip is taken before the sid sample is added
        write_reg(amss_pkg::CFG_SID_MIX, 10'd1);
        drive_frame(make_frame(amss_pkg::SampleMax, amss_pkg::SampleMin,
            amss_pkg::SampleMax, amss_pkg::SampleMin,
            amss_pkg::SampleMin, amss_pkg::SampleMax, 1'b0), 0);
        drive_frame(make_frame(amss_pkg::SampleMax, amss_pkg::SampleMin, 16'sd1, -16'sd1,
            amss_pkg::SampleMax, amss_pkg::SampleMin, 1'b1), 0);
        settle();

        // below the speed floor: every beat twice
        write_reg(amss_pkg::CFG_SPEED, 10'd0);
        run_random(2, 4);
        settle();

        // above the ceiling: one group of ten, then a partial group cut by frame end
        write_reg(amss_pkg::CFG_SPEED, 10'd1023);
        for (int k = 0; k < 10; k++) drive_frame(pick_frame(1000000), 0);
        drive_frame(pick_frame(1000000), 0);
        drive_frame(pick_frame(1000000), 2);
        drive_frame(make_frame(16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 1'b1), 0);
        settle();

        // scale of one just above normal speed
        write_reg(amss_pkg::CFG_SPEED, 10'd150);
        run_random(2, 4);
        settle();

        // group left open, then speed lowered so it completes on the next beat
        write_reg(amss_pkg::CFG_SPEED, 10'd500);
        for (int k = 0; k < 3; k++) drive_frame(pick_frame(1000000), 0);
        settle();
        write_reg(amss_pkg::CFG_SPEED, 10'd200);
        drive_frame(make_frame(-16'sd7, 16'sd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1), 0);
        settle();

        // back-pressure: receiver holds off while the sender keeps going
        write_reg(amss_pkg::CFG_SPEED, 10'd60);
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        run_random(40, 8);
        settle();

        // random phases over the speed range
        for (int p = 0; p < PhaseCount; p++) begin
            spd = (p < 16) ? speeds[p] : int'($urandom_range(0, 1023));
            write_reg(amss_pkg::CFG_SPEED, 10'(spd));
            write_reg(amss_pkg::CFG_SID_MIX, 10'($urandom_range(0, 1)));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            run_random(PhaseBeats, (spd > 199) ? 16 : 6);
            settle();
        end

        if (tracker.pending() != 0) begin
            $error("%0d output beats never arrived", tracker.pending());
            tracker.errors++;
        end
        $display("covered %0d input beats and %0d output beats over %0d register writes,",
            tracker.frames, tracker.pairs, setting_cnt);
        $display("slow, normal and fast speeds with the sid mix on and off");
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/amss_pkg.sv
src/amss_front.sv
src/amss_fifo.sv
src/amss_back.sv
src/audio_mix_and_speed_scale.sv
tb/audio_mix_and_speed_scale_tb.sv
